// File: hw/rtl/gpe_pkg.sv
// Shared constants and types of the gradient palette entry block.
package gpe_pkg;

   localparam int ENTRIES_DEF    = 256;
   localparam int MAX_SHADES_DEF = 6;

   localparam int IDX_W      = 8;
   localparam int CH_W       = 8;
   localparam int NUM_CH     = 3;
   localparam int RGB_W      = NUM_CH * CH_W;
   localparam int COLOUR_W   = 32;
   localparam int SHADES_W   = 3;
   localparam int CSR_IDX_W  = 3;

   localparam logic [CH_W-1:0] ALPHA_OPAQUE = 8'hFF;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NUM_SHADES  = 3'd0,
      CSR_SHADE_ZERO  = 3'd1,
      CSR_SHADE_ONE   = 3'd2,
      CSR_SHADE_TWO   = 3'd3,
      CSR_SHADE_THREE = 3'd4,
      CSR_SHADE_FOUR  = 3'd5,
      CSR_SHADE_FIVE  = 3'd6
   } csr_index_type;

endpackage

// File: hw/rtl/gradient_palette_entry.sv
// Usage: palette entry index in, gradient ARGB colour out, one word per clock.
//
// Request: drive req_entry_index with start high; the word is taken at the
// rising edge where start is high and busy is low. busy is low at all times
// except in the cycle after a reset edge, so one word can be taken every clock.
// Response: rsp_valid strobes for one cycle with rsp_colour once the request has
// passed through eight register stages (segment decode, shade read, channel
// multiply, four two-bit divide steps, output). Throughput is one word per
// clock; the responses keep request order.
// The receiver cannot stall: each colour is shown for exactly one cycle.
// Configuration: csr_index / csr_data with csr_valid and csr_ready; index 0 is
// the shade count, indices 1 to 6 the shades. Write only when no request is in
// flight. The segment length is latched from a constant table on the count write.
// Reset: synchronous; the pipeline empties, shade count becomes two and every
// shade reads as black until written.
module gradient_palette_entry
   import gpe_pkg::*;
#(
   parameter int ENTRIES    = ENTRIES_DEF,
   parameter int MAX_SHADES = MAX_SHADES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [IDX_W-1:0]     req_entry_index,
   output logic                 rsp_valid,
   output logic [COLOUR_W-1:0]  rsp_colour,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [RGB_W-1:0]     csr_data
);

   localparam int SEGW   = $clog2(ENTRIES + 1);
   localparam int TW     = ((SEGW > IDX_W) ? SEGW : IDX_W) + 3;
   localparam int SHW    = $clog2(MAX_SHADES);
   localparam int PW     = 2 * CH_W;
   localparam int NW     = ((SEGW > PW) ? SEGW : PW) + 1;
   localparam int DW     = (NW > SEGW + CH_W) ? NW : SEGW + CH_W;
   localparam int BPS    = 2;
   localparam int DSTEPS = CH_W / BPS;
   localparam int LATENCY = DSTEPS + 4;

   localparam logic [TW-1:0] LAST_ENTRY = TW'(ENTRIES - 1);

   localparam int SEG1 = ((ENTRIES / 1) == 0) ? 1 : ENTRIES / 1;
   localparam int SEG2 = ((ENTRIES / 2) == 0) ? 1 : ENTRIES / 2;
   localparam int SEG3 = ((ENTRIES / 3) == 0) ? 1 : ENTRIES / 3;
   localparam int SEG4 = ((ENTRIES / 4) == 0) ? 1 : ENTRIES / 4;
   localparam int SEG5 = ((ENTRIES / 5) == 0) ? 1 : ENTRIES / 5;

   // configuration
   logic                busy_ff;
   logic [SHADES_W-1:0] k_ff, k_in;
   logic [SEGW-1:0]     seg_ff, seg_in;
   logic [RGB_W-1:0]    shade_mem [MAX_SHADES];
   logic                shade_vld_ff [MAX_SHADES];
   logic                cfg_we;
   logic                shade_we;
   logic [SHW-1:0]      shade_wa;
   logic [SHADES_W-1:0] n_wr;
   logic [CSR_IDX_W-1:0] wa_full;

   // stage 1: segment decode
   logic                v1_ff, zero1_ff;
   logic [SHW-1:0]      ra1_ff, rb1_ff;
   logic [IDX_W-1:0]    j1_ff;
   logic                zero1_in;
   logic [SHW-1:0]      ra1_in, rb1_in;
   logic [IDX_W-1:0]    j1_in;
   logic [TW-1:0]       thr [MAX_SHADES];
   logic [SHADES_W-1:0] cnt;
   logic [TW-1:0]       idx_ext;

   // stage 2: shade read
   logic                v2_ff, zero2_ff;
   logic [IDX_W-1:0]    j2_ff;
   logic [RGB_W-1:0]    sa_ff, sb_ff;
   logic                sav_ff, sbv_ff;

   // stage 3 and divide steps
   logic                vld_ff  [DSTEPS+1];
   logic                zero_ff [DSTEPS+1];
   logic                up_ff   [DSTEPS+1][NUM_CH];
   logic [CH_W-1:0]     s_ff    [DSTEPS+1][NUM_CH];
   logic [NW-1:0]       rem_ff  [DSTEPS+1][NUM_CH];
   logic [CH_W-1:0]     q_ff    [DSTEPS+1][NUM_CH];
   logic                up_in   [DSTEPS+1][NUM_CH];
   logic [CH_W-1:0]     s_in    [DSTEPS+1][NUM_CH];
   logic [NW-1:0]       rem_in  [DSTEPS+1][NUM_CH];
   logic [CH_W-1:0]     q_in    [DSTEPS+1][NUM_CH];

   // output
   logic                rsp_valid_ff;
   logic [COLOUR_W-1:0] rsp_colour_ff, rsp_colour_in;

   assign busy      = busy_ff;
   assign csr_ready = !busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_colour = rsp_colour_ff;

   // configuration decode
   always_comb begin
      cfg_we   = 1'b0;
      shade_we = 1'b0;
      wa_full  = csr_index - CSR_IDX_W'(CSR_SHADE_ZERO);
      shade_wa = wa_full[SHW-1:0];
      n_wr     = csr_data[SHADES_W-1:0];
      if (n_wr < SHADES_W'(2)) begin
         n_wr = SHADES_W'(2);
      end
      if (n_wr > SHADES_W'(MAX_SHADES)) begin
         n_wr = SHADES_W'(MAX_SHADES);
      end
      k_in = n_wr - SHADES_W'(1);
      unique case (k_in)
         SHADES_W'(2): seg_in = SEGW'(SEG2);
         SHADES_W'(3): seg_in = SEGW'(SEG3);
         SHADES_W'(4): seg_in = SEGW'(SEG4);
         SHADES_W'(5): seg_in = SEGW'(SEG5);
         default:      seg_in = SEGW'(SEG1);
      endcase
      if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index)) inside
            CSR_NUM_SHADES: begin
               cfg_we = 1'b1;
            end
            CSR_SHADE_ZERO, CSR_SHADE_ONE, CSR_SHADE_TWO,
            CSR_SHADE_THREE, CSR_SHADE_FOUR, CSR_SHADE_FIVE: begin
               shade_we = (int'(wa_full) < MAX_SHADES);
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         k_ff    <= SHADES_W'(1);
         seg_ff  <= SEGW'(SEG1);
         for (int i = 0; i < MAX_SHADES; i++) begin
            shade_vld_ff[i] <= 1'b0;
         end
      end else begin
         busy_ff <= 1'b0;
         if (cfg_we) begin
            k_ff   <= k_in;
            seg_ff <= seg_in;
         end
         if (shade_we) begin
            shade_vld_ff[shade_wa] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (shade_we) begin
         shade_mem[shade_wa] <= csr_data;
      end
      sa_ff  <= shade_mem[ra1_ff];
      sb_ff  <= shade_mem[rb1_ff];
      sav_ff <= shade_vld_ff[ra1_ff];
      sbv_ff <= shade_vld_ff[rb1_ff];
   end

   // stage 1: which segment, offset within it
   always_comb begin
      idx_ext = TW'(req_entry_index);
      cnt     = '0;
      thr[0]  = '0;
      for (int m = 1; m < MAX_SHADES; m++) begin
         thr[m] = TW'(seg_ff) * TW'(m);
         if ((SHADES_W'(m) <= k_ff) && (idx_ext >= thr[m])) begin
            cnt = cnt + SHADES_W'(1);
         end
      end
      zero1_in = (idx_ext >= LAST_ENTRY);
      if (cnt == k_ff) begin
         ra1_in = k_ff[SHW-1:0];
         rb1_in = k_ff[SHW-1:0];
         j1_in  = '0;
      end else begin
         ra1_in = cnt[SHW-1:0];
         rb1_in = cnt[SHW-1:0] + SHW'(1);
         j1_in  = IDX_W'(idx_ext - thr[cnt[SHW-1:0]]);
      end
   end

   // stage 3: channel difference times offset, bias for rounding up on a fall;
   // then the divide steps, two quotient bits per stage
   always_comb begin
      logic [CH_W-1:0] cs, ce, d;
      logic [PW-1:0]   p;
      logic [NW-1:0]   r;
      logic [CH_W-1:0] qq;
      logic [DW-1:0]   dv;
      int              bi;
      for (int ch = 0; ch < NUM_CH; ch++) begin
         cs = sav_ff ? sa_ff[ch*CH_W +: CH_W] : '0;
         ce = sbv_ff ? sb_ff[ch*CH_W +: CH_W] : '0;
         up_in[0][ch] = (ce >= cs);
         d = up_in[0][ch] ? (ce - cs) : (cs - ce);
         p = d * j2_ff;
         s_in[0][ch]   = cs;
         q_in[0][ch]   = '0;
         rem_in[0][ch] = NW'(p) + (up_in[0][ch] ? NW'(0) : (NW'(seg_ff) - NW'(1)));
      end
      for (int t = 0; t < DSTEPS; t++) begin
         for (int ch = 0; ch < NUM_CH; ch++) begin
            r  = rem_ff[t][ch];
            qq = q_ff[t][ch];
            for (int b = 0; b < BPS; b++) begin
               bi = CH_W - 1 - t * BPS - b;
               dv = DW'(seg_ff) << bi;
               if (DW'(r) >= dv) begin
                  r      = NW'(DW'(r) - dv);
                  qq[bi] = 1'b1;
               end
            end
            rem_in[t+1][ch] = r;
            q_in[t+1][ch]   = qq;
            s_in[t+1][ch]   = s_ff[t][ch];
            up_in[t+1][ch]  = up_ff[t][ch];
         end
      end
   end

   always_comb begin
      logic [RGB_W-1:0] rgb;
      rgb = '0;
      for (int ch = 0; ch < NUM_CH; ch++) begin
         rgb[ch*CH_W +: CH_W] = up_ff[DSTEPS][ch] ?
            (s_ff[DSTEPS][ch] + q_ff[DSTEPS][ch]) :
            (s_ff[DSTEPS][ch] - q_ff[DSTEPS][ch]);
      end
      rsp_colour_in = zero_ff[DSTEPS] ? '0 : {ALPHA_OPAQUE, rgb};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int t = 0; t <= DSTEPS; t++) begin
            vld_ff[t] <= 1'b0;
         end
      end else begin
         v1_ff     <= start && !busy_ff;
         v2_ff     <= v1_ff;
         vld_ff[0] <= v2_ff;
         for (int t = 0; t < DSTEPS; t++) begin
            vld_ff[t+1] <= vld_ff[t];
         end
         rsp_valid_ff <= vld_ff[DSTEPS];
      end
   end

   always_ff @(posedge clock) begin
      zero1_ff   <= zero1_in;
      ra1_ff     <= ra1_in;
      rb1_ff     <= rb1_in;
      j1_ff      <= j1_in;
      zero2_ff   <= zero1_ff;
      j2_ff      <= j1_ff;
      zero_ff[0] <= zero2_ff;
      for (int t = 0; t < DSTEPS; t++) begin
         zero_ff[t+1] <= zero_ff[t];
      end
      for (int t = 0; t <= DSTEPS; t++) begin
         for (int ch = 0; ch < NUM_CH; ch++) begin
            up_ff[t][ch]  <= up_in[t][ch];
            s_ff[t][ch]   <= s_in[t][ch];
            rem_ff[t][ch] <= rem_in[t][ch];
            q_ff[t][ch]   <= q_in[t][ch];
         end
      end
      rsp_colour_ff <= rsp_colour_in;
   end

`ifndef SYNTHESIS
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid)
      else $error("response missing after request");

   a_opaque: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_colour[COLOUR_W-1 -: CH_W] != ALPHA_OPAQUE)) |-> (rsp_colour == '0))
      else $error("transparent colour that is not black");

   a_rem: assert property (@(posedge clock) disable iff (reset)
      vld_ff[DSTEPS] |-> ((DW'(rem_ff[DSTEPS][0]) < DW'(seg_ff))
                       && (DW'(rem_ff[DSTEPS][1]) < DW'(seg_ff))
                       && (DW'(rem_ff[DSTEPS][2]) < DW'(seg_ff))))
      else $error("divide remainder not below segment length");

   a_fall: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[DSTEPS] && !up_ff[DSTEPS][0]) |-> (q_ff[DSTEPS][0] <= s_ff[DSTEPS][0]))
      else $error("falling blend below zero");

   a_shades: assert property (@(posedge clock) disable iff (reset)
      (k_ff >= SHADES_W'(1)) && (k_ff <= SHADES_W'(MAX_SHADES - 1)))
      else $error("shade count out of range");
`endif

endmodule

// File: sim/gpe_checker.sv
`timescale 1ns / 1ps
// Checker: predicts the gradient colour of every taken entry and compares each response word.
module gpe_checker
   import gpe_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 busy,
   input  logic [IDX_W-1:0]     req_entry_index,
   input  logic                 rsp_valid,
   input  logic [COLOUR_W-1:0]  rsp_colour,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [RGB_W-1:0]     csr_data,
   output int                   error_count,
   output int                   colours_due
);

   logic [SHADES_W-1:0] shade_count;
   logic [RGB_W-1:0]    shade_tab [MAX_SHADES_DEF];
   logic [COLOUR_W-1:0] colour_queue [$];
   int                  mismatches = 0;

   task automatic report_mismatch(input string what);
      $display("checker: t=%0t %s", $time, what);
      mismatches++;
   endtask

   function automatic logic [COLOUR_W-1:0] gradient_colour(input logic [IDX_W-1:0] entry);
      int                  n;
      int                  seg;
      int                  seg_no;
      int                  offset;
      int                  lo;
      int                  hi;
      logic [COLOUR_W-1:0] colour;
      n = int'(shade_count);
      if (n < 2) n = 2;
      if (n > MAX_SHADES_DEF) n = MAX_SHADES_DEF;
      if (int'(entry) >= ENTRIES_DEF - 1) return '0;
      seg = ENTRIES_DEF / (n - 1);
      if (seg == 0) seg = 1;
      seg_no = int'(entry) / seg;
      offset = int'(entry) % seg;
      // entries beyond the final segment hold the last shade
      if (seg_no >= n - 1) return {ALPHA_OPAQUE, shade_tab[n-1]};
      colour = {ALPHA_OPAQUE, {RGB_W{1'b0}}};
      for (int c = 0; c < NUM_CH; c++) begin
         lo = int'(shade_tab[seg_no][c*CH_W +: CH_W]);
         hi = int'(shade_tab[seg_no+1][c*CH_W +: CH_W]);
         // numerator never negative, so division is the floor
         colour[c*CH_W +: CH_W] = CH_W'((lo * seg + (hi - lo) * offset) / seg);
      end
      return colour;
   endfunction

   always @(posedge clock) begin : watch
      logic [COLOUR_W-1:0] due;
      if (reset) begin
         shade_count = SHADES_W'(2);
         foreach (shade_tab[k]) shade_tab[k] = '0;
         colour_queue.delete();
      end else begin
         if (rsp_valid) begin
            if (colour_queue.size() == 0) begin
               report_mismatch($sformatf("colour %h with no word due", rsp_colour));
            end else begin
               due = colour_queue.pop_front();
               if (rsp_colour !== due)
                  report_mismatch($sformatf("colour %h, predicted %h", rsp_colour, due));
            end
         end
         if (start && !busy) colour_queue.push_back(gradient_colour(req_entry_index));
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_NUM_SHADES: begin
                  shade_count = csr_data[SHADES_W-1:0];
               end
               CSR_SHADE_ZERO, CSR_SHADE_ONE, CSR_SHADE_TWO,
               CSR_SHADE_THREE, CSR_SHADE_FOUR, CSR_SHADE_FIVE: begin
                  shade_tab[int'(csr_index) - int'(CSR_SHADE_ZERO)] = csr_data;
               end
               default: begin
               end
            endcase
         end
      end
      colours_due <= colour_queue.size();
      error_count <= mismatches;
   end

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// Testbench top: drives palette lookups and register writes into the gradient palette block.
module testbench
   import gpe_pkg::*;
();

   localparam int PIPE_DEPTH      = 8;
   localparam int PHASES          = 8;
   localparam int WORDS_PER_PHASE = 80;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 3'd7;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic [IDX_W-1:0]     req_entry_index;
   logic                 rsp_valid;
   logic [COLOUR_W-1:0]  rsp_colour;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [RGB_W-1:0]     csr_data;
   int                   error_count;
   int                   colours_due;
   bit                   back_to_back;
   logic [IDX_W-1:0]     directed_entries [$] = '{8'd0, 8'd1, 8'd2, 8'd84, 8'd85, 8'd86,
      8'd127, 8'd128, 8'd169, 8'd170, 8'd171, 8'd200, 8'd253, 8'd254, 8'd255, 8'hAA, 8'h55};

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   gradient_palette_entry i_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_entry_index (req_entry_index),
      .rsp_valid       (rsp_valid),
      .rsp_colour      (rsp_colour),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   gpe_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_entry_index (req_entry_index),
      .rsp_valid       (rsp_valid),
      .rsp_colour      (rsp_colour),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .error_count     (error_count),
      .colours_due     (colours_due)
   );

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [RGB_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // start stays high across back-to-back words
   task automatic send_entry(input logic [IDX_W-1:0] entry);
      int gap;
      gap = back_to_back ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start           <= 1'b1;
      req_entry_index <= entry;
      do @(posedge clock); while (busy);
   endtask

   task automatic settle();
      start <= 1'b0;
      @(posedge clock);
      while (colours_due != 0) @(posedge clock);
      repeat (PIPE_DEPTH + 4) @(posedge clock);
   endtask

   initial begin
      logic [RGB_W-1:0] shade;
      reset           <= 1'b1;
      start           <= 1'b0;
      req_entry_index <= '0;
      csr_valid       <= 1'b0;
      csr_index       <= CSR_NUM_SHADES;
      csr_data        <= '0;
      back_to_back     = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // segment edges, last entry, rising and falling channels
      write_reg(CSR_NUM_SHADES, RGB_W'(4));
      write_reg(CSR_SHADE_ZERO, 24'h000000);
      write_reg(CSR_SHADE_ONE, 24'hFFFFFF);
      write_reg(CSR_SHADE_TWO, 24'h00FF80);
      write_reg(CSR_SHADE_THREE, 24'hFF0000);
      write_reg(CSR_SHADE_FOUR, 24'h123456);
      write_reg(CSR_SHADE_FIVE, 24'hABCDEF);
      write_reg(CSR_UNUSED, 24'hFFFFFF);
      foreach (directed_entries[i]) send_entry(directed_entries[i]);

      // shade counts 0 to 7, out-of-range ones included
      for (int p = 0; p < PHASES; p++) begin
         settle();
         write_reg(CSR_NUM_SHADES, {21'($urandom), 3'(p)});
         for (int k = 0; k < MAX_SHADES_DEF; k++) begin
            case (p % 4)
               1: shade = k[0] ? 24'hFFFFFF : 24'h000000;
               2: begin
                  for (int c = 0; c < NUM_CH; c++) begin
                     case ($urandom_range(0, 2))
                        0:       shade[c*CH_W +: CH_W] = 8'h00;
                        1:       shade[c*CH_W +: CH_W] = 8'hFF;
                        default: shade[c*CH_W +: CH_W] = CH_W'($urandom);
                     endcase
                  end
               end
               default: shade = RGB_W'($urandom);
            endcase
            write_reg(CSR_IDX_W'(int'(CSR_SHADE_ZERO) + k), shade);
         end
         if ($urandom_range(0, 1) == 1) write_reg(CSR_UNUSED, RGB_W'($urandom));
         for (int i = 0; i < WORDS_PER_PHASE; i++) begin
            if (i % 16 == 0) back_to_back = ($urandom_range(0, 3) == 0);
            send_entry(($urandom_range(0, 7) == 0) ? IDX_W'($urandom_range(250, 255))
                                                   : IDX_W'($urandom));
         end
      end

      settle();
      if (error_count == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("testbench: errors");
      $finish;
   end

endmodule
